FILE: rtl/wps_pkg.sv
// shared types and constants for the windowed price statistics block
package wps_pkg;

    localparam int DEF_INSTRUMENTS = 16;
    localparam int DEF_WINDOW      = 100;
    localparam int DEF_TREND_LAG   = 10;

    localparam logic [1:0] REG_INSTR_IN_USE = 2'd0;
    localparam logic [1:0] REG_TREND_THR    = 2'd1;
    localparam logic [1:0] REG_VOL_THR      = 2'd2;

    localparam logic [1:0] TREND_NONE    = 2'd0;
    localparam logic [1:0] TREND_RISING  = 2'd1;
    localparam logic [1:0] TREND_FALLING = 2'd2;

    // divider request: 128-bit dividend over 64-bit divisor, 64-bit quotient
    typedef struct packed {
        logic         start;
        logic [127:0] num;
        logic [63:0]  den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;

endpackage

FILE: rtl/wps_divider.sv
// restoring divider shared by all quotients, one quotient bit a cycle
module wps_divider
    import wps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [127:0] r_num;
    logic [63:0]  r_den;
    logic [64:0]  r_rem;
    logic [63:0]  r_quo;
    logic [6:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic [64:0]  n_trial;
    logic [64:0]  n_shift;

    // quotient is known to fit 64 bits: top half of num is below den
    assign n_shift = {r_rem[63:0], r_num[127]};
    assign n_trial = n_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_rem  <= {1'b0, i_req.num[127:64]};
                r_num  <= {i_req.num[63:0], 64'd0};
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_num <= {r_num[126:0], 1'b0};
                if (!n_trial[64]) begin
                    r_rem <= n_trial;
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

FILE: rtl/windowed_price_statistics_core.sv
// windowed price statistics: top level with sequencer, price memory and shared units
//
// input words on s_axis carry an instrument index and a Q16.16 price; each word
// for an instrument in use yields one result word on m_axis, others are dropped.
// configuration must be written through i_cfg_we / i_cfg_idx / i_cfg_data only
// while idle; the block itself does not enforce this. for N held prices (N up to
// WINDOW), once the word is taken a sum pass and a squared-deviation pass each read
// the price memory once a cycle, the 64-bit restoring divider runs four times
// (change, mean, variance, volatility), the square root walks 32 bit pairs, and
// the trend read and result assembly come last. a zero previous price or a zero
// mean skips its division. s_axis_tready is high only in the idle state with no
// result waiting, so no new word is taken until the last result has been sent.
// while m_axis is stalled the result sits in its output register and the block
// does not take a new word. reset clears pointers, counts, last prices and
// registers to their defaults; the price memory needs no clearing because only
// written entries are ever used.
module windowed_price_statistics_core
    import wps_pkg::*;
#(
    parameter int INSTRUMENTS = DEF_INSTRUMENTS,
    parameter int WINDOW      = DEF_WINDOW,
    parameter int TREND_LAG   = DEF_TREND_LAG
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // instrument [3:0], new_price [35:4], zero pad [39:36]
    input  logic [39:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // instrument_out [3:0], relative_change [35:4], change_undefined [36],
    // window_mean [68:37], relative_volatility [100:69], samples_held [107:101],
    // trend [109:108], high_volatility [110], zero pad [111]
    output logic [111:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);

    localparam int IW = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;
    localparam int WW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);
    localparam int AW = $clog2(INSTRUMENTS * WINDOW);
    localparam int SW = 32 + CW;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHG   = 4'd1;
    localparam logic [3:0] ST_SUM   = 4'd2;
    localparam logic [3:0] ST_MEAN  = 4'd3;
    localparam logic [3:0] ST_SQ    = 4'd4;
    localparam logic [3:0] ST_VLO   = 4'd6;
    localparam logic [3:0] ST_SQRT  = 4'd7;
    localparam logic [3:0] ST_RVOL  = 4'd8;
    localparam logic [3:0] ST_TRD   = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [3:0]    r_st;
    logic [4:0]    r_in_use;
    logic [15:0]   r_trend_thr;
    logic [15:0]   r_vol_thr;
    logic [WW-1:0] r_wp   [INSTRUMENTS];
    logic [CW-1:0] r_cnt  [INSTRUMENTS];
    logic [31:0]   r_last [INSTRUMENTS];
    logic [31:0]   r_mem  [INSTRUMENTS * WINDOW];
    logic [31:0]   r_rd;

    logic [IW-1:0] r_inst;
    logic [3:0]    r_inst_raw;
    logic [31:0]   r_price;
    logic [31:0]   r_prev;
    logic [CW-1:0] r_n;
    logic [CW:0]   r_i;
    logic          r_phase;
    logic [SW-1:0] r_sum;
    logic [31:0]   r_mean;
    logic [95:0]   r_sq;
    logic [63:0]   r_var;
    logic [63:0]   r_rem_v;
    logic [31:0]   r_root;
    logic [5:0]    r_sqi;
    logic [31:0]   r_rel;
    logic          r_undef;
    logic [31:0]   r_rvol;
    logic [31:0]   r_recent;
    logic          r_div_wait;
    logic [111:0]  r_out;
    logic          r_ovalid;
    logic [31:0]   r_older;

    t_div_req div_req;
    t_div_rsp div_rsp;

    wps_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    logic [IW-1:0] in_inst;
    logic          in_ok;
    logic          in_fire;
    logic [AW-1:0] base;
    logic [AW-1:0] rd_addr;
    logic [31:0]   dev;
    logic [63:0]   sqd;
    logic [65:0]   sq_trial;
    logic [WW-1:0] lag_idx;
    logic [47:0]   lim;
    logic [47:0]   up_d;
    logic [47:0]   dn_d;

    assign in_inst = s_axis_tdata[IW-1:0];
    assign in_ok   = ({1'b0, s_axis_tdata[3:0]} < r_in_use)
                     && ({28'd0, s_axis_tdata[3:0]} < 32'(INSTRUMENTS));
    assign s_axis_tready = (r_st == ST_IDLE) && !r_ovalid;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    assign base    = AW'(r_inst) * AW'(WINDOW);
    assign lag_idx = (r_wp[r_inst] >= WW'(TREND_LAG))
                     ? r_wp[r_inst] - WW'(TREND_LAG)
                     : r_wp[r_inst] + WW'(WINDOW - TREND_LAG);
    assign rd_addr = (r_st == ST_TRD) ? base + AW'(lag_idx) : base + AW'(r_i[CW-1:0]);
    assign dev     = (r_rd >= r_mean) ? r_rd - r_mean : r_mean - r_rd;
    assign sqd     = dev * dev;
    assign sq_trial = {r_rem_v, r_var[63:62]} - {r_root, 2'b01};
    assign lim     = {16'd0, r_trend_thr} * {16'd0, r_older};
    assign up_d    = {r_recent - r_older, 16'd0};
    assign dn_d    = {r_older - r_recent, 16'd0};

    always_ff @(posedge i_clk) begin
        if (r_st == ST_CHG) begin
            r_mem[base + AW'(r_wp[r_inst])] <= r_price;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_comb begin
        div_req = '0;
        unique case (r_st)
            ST_CHG:  begin
                div_req.num = {80'd0, (r_price >= r_prev) ? r_price - r_prev
                                                          : r_prev - r_price, 16'd0};
                div_req.den = {32'd0, r_prev};
            end
            ST_MEAN: begin
                div_req.num = {(128 - SW)'(0), r_sum};
                div_req.den = {(64 - CW)'(0), r_n};
            end
            ST_VLO:  begin
                div_req.num = {32'd0, r_sq};
                div_req.den = {(64 - CW)'(0), r_n};
            end
            ST_RVOL: begin
                div_req.num = {80'd0, r_root, 16'd0};
                div_req.den = {32'd0, r_mean};
            end
            default: ;
        endcase
        div_req.start = !r_div_wait && !r_phase &&
                        (r_st == ST_CHG || r_st == ST_MEAN
                         || r_st == ST_VLO || r_st == ST_RVOL)
                        && !(r_st == ST_CHG && r_prev == 32'd0)
                        && !(r_st == ST_RVOL && r_mean == 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_in_use    <= 5'd16;
            r_trend_thr <= 16'd3277;
            r_vol_thr   <= 16'd3277;
            r_ovalid    <= 1'b0;
            r_div_wait  <= 1'b0;
            r_phase     <= 1'b0;
            for (int k = 0; k < INSTRUMENTS; k++) begin
                r_wp[k]   <= '0;
                r_cnt[k]  <= '0;
                r_last[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                priority case (i_cfg_idx)
                    REG_INSTR_IN_USE: r_in_use    <= i_cfg_data[4:0];
                    REG_TREND_THR:    r_trend_thr <= i_cfg_data;
                    REG_VOL_THR:      r_vol_thr   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (div_req.start) begin
                r_div_wait <= 1'b1;
            end
            if (div_rsp.done) begin
                r_div_wait <= 1'b0;
            end
            unique case (r_st)
                ST_IDLE: begin
                    if (in_fire && in_ok) begin
                        r_inst     <= in_inst;
                        r_inst_raw <= s_axis_tdata[3:0];
                        r_price    <= s_axis_tdata[35:4];
                        r_prev     <= r_last[in_inst];
                        r_st       <= ST_CHG;
                    end
                end
                ST_CHG: begin
                    if (r_prev == 32'd0 || div_rsp.done) begin
                        r_undef <= (r_prev == 32'd0);
                        if (r_prev == 32'd0) begin
                            r_rel <= '0;
                        end else if (r_price >= r_prev) begin
                            r_rel <= (div_rsp.quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                                  : div_rsp.quo[31:0];
                        end else begin
                            r_rel <= 32'd0 - div_rsp.quo[31:0];
                        end
                        r_last[r_inst] <= r_price;
                        r_wp[r_inst]   <= (r_wp[r_inst] == WW'(WINDOW - 1))
                                          ? '0 : r_wp[r_inst] + WW'(1);
                        r_n <= (r_cnt[r_inst] >= CW'(WINDOW)) ? CW'(WINDOW)
                                                               : r_cnt[r_inst] + CW'(1);
                        r_cnt[r_inst] <= (r_cnt[r_inst] >= CW'(WINDOW)) ? CW'(WINDOW)
                                                                : r_cnt[r_inst] + CW'(1);
                        r_i   <= '0;
                        r_sum <= '0;
                        r_st  <= ST_SUM;
                        r_phase <= 1'b0;
                    end
                end
                ST_SUM: begin
                    // read address issues at r_i, data lands in r_rd on the next cycle
                    if (r_phase) begin
                        r_sum <= r_sum + SW'(r_rd);
                    end
                    if (r_i[CW-1:0] == r_n || r_i == {1'b0, r_n}) begin
                        r_phase <= 1'b0;
                        r_st    <= ST_MEAN;
                    end else begin
                        r_i     <= r_i + (CW + 1)'(1);
                        r_phase <= 1'b1;
                    end
                end
                ST_MEAN: begin
                    if (div_rsp.done) begin
                        r_mean <= div_rsp.quo[31:0];
                        r_i    <= '0;
                        r_sq   <= '0;
                        r_phase <= 1'b1;
                        r_st   <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    if (r_i != '0) begin
                        r_sq <= r_sq + {32'd0, sqd};
                    end
                    if (r_i == {1'b0, r_n}) begin
                        r_phase <= 1'b0;
                        r_st    <= ST_VLO;
                    end else begin
                        r_i <= r_i + (CW + 1)'(1);
                    end
                end
                ST_VLO: begin
                    if (div_rsp.done) begin
                        // quotient above 64 bits saturates the variance
                        r_var   <= (r_sq[95:64] >= {(32 - CW)'(0), r_n}) ? '1
                                                                        : div_rsp.quo;
                        r_rem_v <= '0;
                        r_root  <= '0;
                        r_sqi   <= '0;
                        r_st    <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (!sq_trial[65]) begin
                        r_rem_v <= sq_trial[63:0];
                        r_root  <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem_v <= {r_rem_v[61:0], r_var[63:62]};
                        r_root  <= {r_root[30:0], 1'b0};
                    end
                    r_var <= {r_var[61:0], 2'b00};
                    r_sqi <= r_sqi + 6'd1;
                    if (r_sqi == 6'd31) begin
                        r_st <= ST_RVOL;
                    end
                end
                ST_RVOL: begin
                    if (r_mean == 32'd0 || div_rsp.done) begin
                        r_rvol <= (r_mean == 32'd0) ? '0
                                  : (div_rsp.quo > 64'hFFFF_FFFF) ? '1
                                  : div_rsp.quo[31:0];
                        r_recent <= r_price;
                        r_phase  <= 1'b0;
                        r_st     <= ST_TRD;
                    end
                end
                ST_TRD: begin
                    if (!r_phase) begin
                        r_phase <= 1'b1;
                    end else begin
                        r_older <= r_rd;
                        r_phase <= 1'b0;
                        r_st    <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_phase) begin
                        r_phase <= 1'b1;
                    end else begin
                        r_phase  <= 1'b0;
                        r_st     <= ST_IDLE;
                        r_ovalid <= 1'b1;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // result word is assembled once the older price has landed
    always_ff @(posedge i_clk) begin
        if (r_st == ST_OUT && r_phase) begin
            r_out <= {1'b0,
                      (r_n >= CW'(TREND_LAG)) && (r_mean != 0)
                          && (r_rvol > {16'd0, r_vol_thr}),
                      (r_n < CW'(TREND_LAG)) ? TREND_NONE
                          : (r_recent > r_older && up_d > lim) ? TREND_RISING
                          : (r_older > r_recent && dn_d > lim) ? TREND_FALLING
                          : TREND_NONE,
                      7'(r_n), r_rvol, r_mean, r_undef, r_rel, r_inst_raw};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

endmodule

FILE: rtl/windowed_price_statistics_core_chk.sv
// port-level checker for the windowed price statistics block, bound to the top level
module windowed_price_statistics_core_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata
);

    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result waits");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result too early");

    a_trend_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[109:108] != 2'd3)
        else $error("bad trend code");

endmodule

bind windowed_price_statistics_core windowed_price_statistics_core_chk u_chk (.*);

FILE: bench/price_stats_monitor.sv
// checker for the windowed price statistics block: predicts every result word and compares
module price_stats_monitor
    import wps_pkg::*;
#(
    parameter int INSTRUMENTS = DEF_INSTRUMENTS,
    parameter int WINDOW      = DEF_WINDOW,
    parameter int TREND_LAG   = DEF_TREND_LAG
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [39:0]  i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [111:0] i_out_data,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    output int           o_errors,
    output int           o_pending,
    output int           o_results,
    output int           o_dropped
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        hvol;
        logic [1:0]  trend;
        logic [6:0]  held;
        logic [31:0] vol;
        logic [31:0] mean;
        logic        undef;
        logic [31:0] change;
        logic [3:0]  inst;
    } t_stats;

    logic [31:0] ring [INSTRUMENTS][WINDOW];
    int          wr_slot [INSTRUMENTS];
    int          held_cnt [INSTRUMENTS];
    logic [31:0] prev_price [INSTRUMENTS];
    logic [4:0]  in_use;
    logic [15:0] trend_thr;
    logic [15:0] vol_thr;
    t_stats      stats_due [$];

    assign o_pending = stats_due.size();

    // floor square root, one result bit at a time from the top
    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int k = 31; k >= 0; k--) begin
            t = r | (64'd1 << k);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    task automatic predict_stats(input logic [3:0] inst, input logic [31:0] price,
                                 output bit taken, output t_stats r);
        logic [63:0]  prev, newest, q, sum, mean, d, var_q, sd, older, lim, n;
        logic [127:0] sqs, qv;
        taken = 0;
        r = '0;
        if (inst >= in_use || inst >= INSTRUMENTS) return;
        taken = 1;
        r.inst = inst;
        prev = prev_price[inst];
        newest = price;
        prev_price[inst] = price;
        if (prev == 0) begin
            r.undef = 1'b1;
        end else if (newest >= prev) begin
            q = ((newest - prev) << 16) / prev;
            r.change = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end else begin
            q = ((prev - newest) << 16) / prev;
            r.change = 32'd0 - q[31:0];
        end
        ring[inst][wr_slot[inst]] = price;
        wr_slot[inst] = (wr_slot[inst] + 1) % WINDOW;
        if (held_cnt[inst] < WINDOW) held_cnt[inst]++;
        n = held_cnt[inst];
        sum = '0;
        for (int i = 0; i < held_cnt[inst]; i++) sum += ring[inst][i];
        mean = sum / n;
        sqs = '0;
        for (int i = 0; i < held_cnt[inst]; i++) begin
            d = (ring[inst][i] >= mean) ? ring[inst][i] - mean : mean - ring[inst][i];
            sqs += d * d;
        end
        qv = sqs / n;
        var_q = (|qv[127:64]) ? '1 : qv[63:0];
        sd = root64(var_q);
        if (mean != 0) begin
            q = (sd << 16) / mean;
            r.vol = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        end
        r.mean = mean[31:0];
        r.held = n[6:0];
        r.trend = TREND_NONE;
        if (held_cnt[inst] >= TREND_LAG) begin
            older = ring[inst][(wr_slot[inst] + WINDOW - TREND_LAG) % WINDOW];
            lim = trend_thr * older;
            if (newest > older && ((newest - older) << 16) > lim) r.trend = TREND_RISING;
            else if (older > newest && ((older - newest) << 16) > lim) r.trend = TREND_FALLING;
            if (mean != 0 && r.vol > vol_thr) r.hvol = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
            o_errors++;
        end
    endtask

    initial begin
        o_errors = 0;
        o_results = 0;
        o_dropped = 0;
    end

    always @(posedge i_clk) begin
        t_stats r;
        t_stats got;
        bit     taken;
        if (!i_rst_n) begin
            for (int i = 0; i < INSTRUMENTS; i++) begin
                wr_slot[i] = 0;
                held_cnt[i] = 0;
                prev_price[i] = '0;
            end
            in_use = 5'd16;
            trend_thr = 16'd3277;
            vol_thr = 16'd3277;
            stats_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_INSTR_IN_USE: in_use = i_cfg_data[4:0];
                    REG_TREND_THR:    trend_thr = i_cfg_data;
                    REG_VOL_THR:      vol_thr = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_stats(i_in_data[3:0], i_in_data[35:4], taken, r);
                if (taken) stats_due.push_back(r);
                else o_dropped++;
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[110:0];
                o_results++;
                if (stats_due.size() == 0) begin
                    $display("%0t: result word with none expected, got %h", $realtime, got);
                    o_errors++;
                end else begin
                    r = stats_due.pop_front();
                    check_field("instrument_out", r.inst, got.inst);
                    check_field("relative_change", r.change, got.change);
                    check_field("change_undefined", r.undef, got.undef);
                    check_field("window_mean", r.mean, got.mean);
                    check_field("relative_volatility", r.vol, got.vol);
                    check_field("samples_held", r.held, got.held);
                    check_field("trend", r.trend, got.trend);
                    check_field("high_volatility", r.hvol, got.hvol);
                end
            end
        end
    end
endmodule

FILE: bench/windowed_price_statistics_core_test.sv
// stimulus and verdict for the windowed price statistics block
module windowed_price_statistics_core_test;
    import wps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE = 800;
    localparam longint CYCLE_LIMIT = 4_000_000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_idx;
    logic [15:0]  i_cfg_data;

    int           errors, pending, results, dropped;
    longint       cycles;
    bit           quiet;
    int           hold_req;
    int           hold_left;
    int           stall_left;
    int           words_sent;
    logic [31:0]  level [16];

    windowed_price_statistics_core i_dut (.*);

    price_stats_monitor i_mon (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results), .o_dropped(dropped)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("windowed_price_statistics_core_test: done, errors");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
            stall_left <= 0;
        end else if (hold_req > 0) begin
            hold_left <= hold_req;
            hold_req <= 0;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_word(input logic [3:0] inst, input logic [31:0] price);
        @(posedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 12)) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, price, inst};
        do @(posedge i_clk); while (!s_axis_tready);
        s_axis_tvalid <= 1'b0;
        words_sent++;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly a random walk per instrument, with zeros and full-range noise mixed in
    function automatic logic [31:0] next_price(input int inst);
        int          pick;
        logic [31:0] step;
        pick = $urandom_range(0, 99);
        if (pick < 3) return 32'd0;
        if (pick < 8) return $urandom;
        step = $urandom_range(0, (level[inst] >> 4) + 1);
        if ($urandom_range(0, 1) && level[inst] > step + 32'd16) level[inst] -= step;
        else if (level[inst] < 32'hF000_0000) level[inst] += step;
        return level[inst];
    endfunction

    initial begin
        int n_in_use [6] = '{16, 4, 16, 1, 11, 16};
        int t_thr [6] = '{0, 65535, 3277, 655, 16384, 3277};
        int v_thr [6] = '{65535, 0, 3277, 1000, 20000, 3277};
        int inst;
        cycles = 0;
        quiet = 0;
        hold_req = 0;
        words_sent = 0;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        for (int i = 0; i < 16; i++) level[i] = $urandom_range(32'h0001_0000, 32'h0400_0000);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero previous price, zero mean, price extremes
        send_word(4'd0, 32'd0);
        send_word(4'd0, 32'd0);
        send_word(4'd0, 32'hFFFF_FFFF);
        send_word(4'd0, 32'd1);
        send_word(4'd0, 32'hFFFF_FFFF);
        send_word(4'd15, 32'h0001_0000);
        // steady climb then a drop for trend and volatility flags
        for (int k = 0; k < 11; k++) send_word(4'd1, 32'h0064_0000 + k * 32'h000A_0000);
        for (int k = 0; k < 4; k++) send_word(4'd1, 32'h0020_0000 >> k);
        drain();
        // out-of-use indices are dropped, unknown register index ignored
        write_reg(REG_INSTR_IN_USE, 16'd3);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_word(4'd5, 32'h1234_5678);
        send_word(4'd2, 32'h0002_0000);
        drain();
        write_reg(REG_INSTR_IN_USE, 16'd0);
        send_word(4'd0, 32'h0003_0000);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_reg(REG_INSTR_IN_USE, 16'(n_in_use[ph]));
            write_reg(REG_TREND_THR, 16'(t_thr[ph]));
            write_reg(REG_VOL_THR, 16'(v_thr[ph]));
            if (ph == 5) quiet = 1;
            for (int k = 0; k < 220; k++) begin
                if (ph == 2 && k == 20) hold_req = 3000;
                if (ph == 3 && k == 100) while (pending != 0) @(posedge i_clk);
                if ($urandom_range(0, 19) == 0) inst = $urandom_range(0, 15);
                else inst = $urandom_range(0, (n_in_use[ph] > 0) ? n_in_use[ph] - 1 : 0);
                send_word(inst[3:0], next_price(inst));
            end
        end

        drain();
        $display("sent %0d price words (%0d dropped as out of use), checked %0d results",
                 words_sent, dropped, results);
        $display("six register settings incl. threshold extremes, long output hold-off");
        if (errors == 0 && pending == 0)
            $display("windowed_price_statistics_core_test: done, clean");
        else
            $display("windowed_price_statistics_core_test: done, errors");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/wps_pkg.sv
rtl/wps_divider.sv
rtl/windowed_price_statistics_core.sv
rtl/windowed_price_statistics_core_chk.sv
bench/price_stats_monitor.sv
bench/windowed_price_statistics_core_test.sv
